// ===== design/htbp_pkg.sv =====
// ----------------------------------------------------------------------------
// htbp_pkg
// Shared types and constants for the hierarchical token bucket policer.
// ----------------------------------------------------------------------------
`default_nettype none
package htbp_pkg;

  localparam int CONN_SLOTS   = 1024;
  localparam int PID_SLOTS    = 1024;
  localparam int CGROUP_SLOTS = 1024;
  localparam int CONN_AW      = $clog2(CONN_SLOTS);
  localparam int PID_AW       = $clog2(PID_SLOTS);
  localparam int CGROUP_AW    = $clog2(CGROUP_SLOTS);
  localparam int MAX_SLOTS    = (CONN_SLOTS > PID_SLOTS) ?
                                ((CONN_SLOTS > CGROUP_SLOTS) ? CONN_SLOTS : CGROUP_SLOTS) :
                                ((PID_SLOTS > CGROUP_SLOTS) ? PID_SLOTS : CGROUP_SLOTS);
  localparam int CLR_W        = $clog2(MAX_SLOTS);

  localparam int IDX_W   = 10;
  localparam int RATE_W  = 40;
  localparam int BURST_W = 32;
  localparam int TOK_W   = 32;
  localparam int TIME_W  = 64;
  localparam int BYTES_W = 16;

  localparam int MUL_CHUNK = 16;
  localparam int MUL_STEPS = TIME_W / MUL_CHUNK;
  localparam int STEP_W    = $clog2(MUL_STEPS);

  // x / 1e9 == ((x >> 9) * DIV_RECIP) >> 75 for every 64-bit x; 1e9 is 2^9 * 5^9
  localparam int                DIV_PRE_SHIFT  = 9;
  localparam logic [TIME_W-1:0] DIV_RECIP      = 64'h0044_B82F_A09B_5A53;
  // 75 less the 48 bits dropped while the chunks are summed
  localparam int                DIV_POST_SHIFT = 27;

  typedef enum logic {
    OP_POLICE = 1'b0,
    OP_WRITE  = 1'b1
  } htbp_op_t;

  typedef enum logic [1:0] {
    LVL_CONN   = 2'd0,
    LVL_PID    = 2'd1,
    LVL_CGROUP = 2'd2,
    LVL_GLOBAL = 2'd3
  } htbp_level_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LIMIT,
    S_LEVEL,
    S_FETCH,
    S_CHARGE,
    S_DONE
  } htbp_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_SUM,
    B_CHECK,
    B_DONE
  } htbp_bstate_t;

  typedef struct packed {
    logic                en;
    htbp_level_t         lvl;
    logic [IDX_W-1:0]    addr;
  } htbp_tbl_rd_t;

  typedef struct packed {
    logic [RATE_W-1:0]   rate;
    logic [BURST_W-1:0]  burst;
    logic [TOK_W-1:0]    tokens;
    logic [TIME_W-1:0]   last;
  } htbp_tbl_data_t;

  typedef struct packed {
    logic                en;
    htbp_level_t         lvl;
    logic [IDX_W-1:0]    addr;
    logic [TOK_W-1:0]    tokens;
    logic [TIME_W-1:0]   last;
  } htbp_bkt_wr_t;

  typedef struct packed {
    logic                en;
    htbp_level_t         lvl;
    logic [IDX_W-1:0]    addr;
    logic [RATE_W-1:0]   rate;
    logic [BURST_W-1:0]  burst;
  } htbp_lim_wr_t;

  typedef struct packed {
    logic                start;
    logic [RATE_W-1:0]   rate;
    logic [BURST_W-1:0]  burst;
    logic [TOK_W-1:0]    tokens;
    logic [TIME_W-1:0]   last;
    logic [TIME_W-1:0]   now;
    logic [BYTES_W-1:0]  bytes;
  } htbp_bkt_req_t;

  typedef struct packed {
    logic                done;
    logic                pass;
    logic                limited;
    logic [TOK_W-1:0]    tokens;
    logic [TIME_W-1:0]   last;
  } htbp_bkt_rsp_t;

endpackage
`default_nettype wire

// ===== design/hierarchical_token_bucket_policer.sv =====
// ----------------------------------------------------------------------------
// hierarchical_token_bucket_policer
// Four-level token bucket policer: connection, process, cgroup, global.
// ----------------------------------------------------------------------------
// After reset the block sweeps its limit and bucket tables and accepts
// no item until the sweep ends. Every item is accepted in S_IDLE and hands
// its result to the output register in S_DONE; while an earlier result still
// waits there, the block holds in S_DONE. A limit write (opcode 1) passes
// through S_LIMIT. A police item walks the four levels in order through one
// shared bucket unit: a skipped level is passed over, an unlimited one is
// not charged, a limited one without refill is only charged, and a refilling
// one first runs the 4-step 64x16 multiply of rate by elapsed time and the
// 4-step reciprocal multiply that divides by one second.
`default_nettype none
module hierarchical_token_bucket_policer (
  input  wire          clk,
  input  wire          rst_n,
  // opcode, conn_index, pid_index, cgroup_index, now_ns, packet_bytes,
  // target_level, target_index, new_rate, new_burst; zero padded
  input  wire  [199:0] in_tdata,
  input  wire          in_tvalid,
  output logic         in_tready,
  // pass, drop_level; zero padded
  output logic [7:0]   out_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  input  wire          cfg_we,
  input  wire          cfg_index,
  input  wire  [39:0]  cfg_wdata
);
  import htbp_pkg::*;

  htbp_state_t state_r, state_nxt;

  logic               op_r;
  logic [IDX_W-1:0]   ci_r, pi_r, gi_r, ti_r;
  logic [TIME_W-1:0]  now_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [1:0]         tl_r;
  logic [RATE_W-1:0]  nrate_r;
  logic [BURST_W-1:0] nburst_r;
  htbp_level_t        lvl_r;
  logic               pass_r;
  htbp_level_t        drop_r;

  logic [RATE_W-1:0]  grate_r;
  logic [BURST_W-1:0] gburst_r;
  logic [TOK_W-1:0]   gtok_r;
  logic [TIME_W-1:0]  glast_r;

  logic               ovalid_r;
  logic               opass_r;
  htbp_level_t        odrop_r;

  htbp_tbl_rd_t   rd;
  htbp_tbl_data_t rd_data;
  htbp_bkt_wr_t   bkt_wr;
  htbp_lim_wr_t   lim_wr;
  htbp_bkt_req_t  req;
  htbp_bkt_rsp_t  rsp;
  logic           clr_busy;

  logic [IDX_W-1:0] cur_idx;
  logic             skip;
  logic             in_acc;
  logic             out_free;

  htbp_tables u_tables (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd       (rd),
    .rd_data  (rd_data),
    .bkt_wr   (bkt_wr),
    .lim_wr   (lim_wr),
    .clr_busy (clr_busy)
  );

  htbp_bucket u_bucket (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    case (lvl_r)
      LVL_CONN:   begin cur_idx = ci_r; skip = (ci_r == '0) || (32'(ci_r) >= CONN_SLOTS); end
      LVL_PID:    begin cur_idx = pi_r; skip = (pi_r == '0) || (32'(pi_r) >= PID_SLOTS); end
      LVL_CGROUP: begin cur_idx = gi_r; skip = (gi_r == '0) || (32'(gi_r) >= CGROUP_SLOTS); end
      default:    begin cur_idx = '0;   skip = 1'b0; end
    endcase
  end

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !ovalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (!clr_busy) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tdata[0] == OP_WRITE) ? S_LIMIT : S_LEVEL;
        end
      end
      S_LIMIT: state_nxt = S_DONE;
      S_LEVEL: begin
        if (!skip) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_CHARGE;
      S_CHARGE: begin
        if (rsp.done) begin
          state_nxt = (!rsp.pass || lvl_r == LVL_GLOBAL) ? S_DONE : S_LEVEL;
        end
      end
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == S_IDLE);

    rd.en   = (state_r == S_LEVEL) && !skip && (lvl_r != LVL_GLOBAL);
    rd.lvl  = lvl_r;
    rd.addr = cur_idx;

    req.start  = (state_r == S_FETCH);
    req.rate   = (lvl_r == LVL_GLOBAL) ? grate_r : rd_data.rate;
    req.burst  = (lvl_r == LVL_GLOBAL) ? gburst_r : rd_data.burst;
    req.tokens = (lvl_r == LVL_GLOBAL) ? gtok_r : rd_data.tokens;
    req.last   = (lvl_r == LVL_GLOBAL) ? glast_r : rd_data.last;
    req.now    = now_r;
    req.bytes  = bytes_r;

    bkt_wr.en     = (state_r == S_CHARGE) && rsp.done && rsp.limited &&
                    (lvl_r != LVL_GLOBAL);
    bkt_wr.lvl    = lvl_r;
    bkt_wr.addr   = cur_idx;
    bkt_wr.tokens = rsp.tokens;
    bkt_wr.last   = rsp.last;

    lim_wr.en    = (state_r == S_LIMIT) &&
                   (((tl_r == 2'(LVL_CONN)) && (32'(ti_r) < CONN_SLOTS)) ||
                    ((tl_r == 2'(LVL_PID)) && (32'(ti_r) < PID_SLOTS)) ||
                    ((tl_r == 2'(LVL_CGROUP)) && (32'(ti_r) < CGROUP_SLOTS)));
    lim_wr.lvl   = htbp_level_t'(tl_r);
    lim_wr.addr  = ti_r;
    lim_wr.rate  = nrate_r;
    lim_wr.burst = nburst_r;

    out_tvalid = ovalid_r;
    out_tdata  = {5'b0, odrop_r, opass_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      ovalid_r <= 1'b0;
      grate_r  <= '0;
      gburst_r <= '0;
      gtok_r   <= '0;
      glast_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == 1'b0) begin
          grate_r <= cfg_wdata;
        end else begin
          gburst_r <= cfg_wdata[BURST_W-1:0];
        end
      end
      if (state_r == S_CHARGE && rsp.done && rsp.limited && lvl_r == LVL_GLOBAL) begin
        gtok_r  <= rsp.tokens;
        glast_r <= rsp.last;
      end
      if (state_r == S_DONE && out_free) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_tdata[0];
      ci_r     <= in_tdata[10:1];
      pi_r     <= in_tdata[20:11];
      gi_r     <= in_tdata[30:21];
      now_r    <= in_tdata[94:31];
      bytes_r  <= in_tdata[110:95];
      tl_r     <= in_tdata[112:111];
      ti_r     <= in_tdata[122:113];
      nrate_r  <= in_tdata[162:123];
      nburst_r <= in_tdata[194:163];
      lvl_r    <= LVL_CONN;
      pass_r   <= 1'b1;
      drop_r   <= LVL_CONN;
    end else if (state_r == S_LEVEL && skip) begin
      lvl_r <= htbp_level_t'(lvl_r + 2'd1);
    end else if (state_r == S_CHARGE && rsp.done) begin
      if (!rsp.pass) begin
        pass_r <= 1'b0;
        drop_r <= lvl_r;
      end else if (lvl_r != LVL_GLOBAL) begin
        lvl_r <= htbp_level_t'(lvl_r + 2'd1);
      end
    end
    if (state_r == S_DONE && out_free) begin
      opass_r <= pass_r || (op_r == OP_WRITE);
      odrop_r <= (op_r == OP_WRITE) ? LVL_CONN : drop_r;
    end
  end

  a_pass_no_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[2:1] == 2'd0)
    else $error("passing result carries a drop level");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_tready)
    else $error("item accepted during table clear");

  a_done_in_charge: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> state_r == S_CHARGE)
    else $error("bucket unit finished outside a charge");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised without a finished item");

  a_skip_not_global: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LEVEL && lvl_r == LVL_GLOBAL |=> state_r == S_FETCH)
    else $error("global level skipped");

endmodule
`default_nettype wire

// ===== design/htbp_tables.sv =====
// ----------------------------------------------------------------------------
// htbp_tables
// Limit and bucket memories of the three indexed levels, with a clearing
// sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module htbp_tables (
  input  wire                    clk,
  input  wire                    rst_n,
  input  htbp_pkg::htbp_tbl_rd_t rd,
  output htbp_pkg::htbp_tbl_data_t rd_data,
  input  htbp_pkg::htbp_bkt_wr_t bkt_wr,
  input  htbp_pkg::htbp_lim_wr_t lim_wr,
  output logic                   clr_busy
);
  import htbp_pkg::*;

  localparam int LIM_W = RATE_W + BURST_W;
  localparam int BKT_W = TOK_W + TIME_W;

  logic [LIM_W-1:0] conn_lim_mem [CONN_SLOTS];
  logic [BKT_W-1:0] conn_bkt_mem [CONN_SLOTS];
  logic [LIM_W-1:0] pid_lim_mem  [PID_SLOTS];
  logic [BKT_W-1:0] pid_bkt_mem  [PID_SLOTS];
  logic [LIM_W-1:0] cg_lim_mem   [CGROUP_SLOTS];
  logic [BKT_W-1:0] cg_bkt_mem   [CGROUP_SLOTS];

  logic [LIM_W-1:0] conn_lim_r, pid_lim_r, cg_lim_r;
  logic [BKT_W-1:0] conn_bkt_r, pid_bkt_r, cg_bkt_r;
  htbp_level_t      rd_lvl_r;

  logic [CLR_W-1:0] clr_cnt_r;
  logic             clr_act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_act_r) begin
      if (clr_cnt_r == CLR_W'(MAX_SLOTS - 1)) begin
        clr_act_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign clr_busy = clr_act_r;

  // Each memory takes either the clearing row or one functional write.
  always_ff @(posedge clk) begin
    if (clr_act_r) begin
      if (32'(clr_cnt_r) < CONN_SLOTS) begin
        conn_lim_mem[clr_cnt_r[CONN_AW-1:0]] <= '0;
        conn_bkt_mem[clr_cnt_r[CONN_AW-1:0]] <= '0;
      end
      if (32'(clr_cnt_r) < PID_SLOTS) begin
        pid_lim_mem[clr_cnt_r[PID_AW-1:0]] <= '0;
        pid_bkt_mem[clr_cnt_r[PID_AW-1:0]] <= '0;
      end
      if (32'(clr_cnt_r) < CGROUP_SLOTS) begin
        cg_lim_mem[clr_cnt_r[CGROUP_AW-1:0]] <= '0;
        cg_bkt_mem[clr_cnt_r[CGROUP_AW-1:0]] <= '0;
      end
    end else begin
      if (lim_wr.en) begin
        case (lim_wr.lvl)
          LVL_CONN:   conn_lim_mem[lim_wr.addr[CONN_AW-1:0]] <= {lim_wr.rate, lim_wr.burst};
          LVL_PID:    pid_lim_mem[lim_wr.addr[PID_AW-1:0]] <= {lim_wr.rate, lim_wr.burst};
          LVL_CGROUP: cg_lim_mem[lim_wr.addr[CGROUP_AW-1:0]] <= {lim_wr.rate, lim_wr.burst};
          default: ;
        endcase
      end
      if (bkt_wr.en) begin
        case (bkt_wr.lvl)
          LVL_CONN:   conn_bkt_mem[bkt_wr.addr[CONN_AW-1:0]] <= {bkt_wr.tokens, bkt_wr.last};
          LVL_PID:    pid_bkt_mem[bkt_wr.addr[PID_AW-1:0]] <= {bkt_wr.tokens, bkt_wr.last};
          LVL_CGROUP: cg_bkt_mem[bkt_wr.addr[CGROUP_AW-1:0]] <= {bkt_wr.tokens, bkt_wr.last};
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      conn_lim_r <= conn_lim_mem[rd.addr[CONN_AW-1:0]];
      conn_bkt_r <= conn_bkt_mem[rd.addr[CONN_AW-1:0]];
      pid_lim_r  <= pid_lim_mem[rd.addr[PID_AW-1:0]];
      pid_bkt_r  <= pid_bkt_mem[rd.addr[PID_AW-1:0]];
      cg_lim_r   <= cg_lim_mem[rd.addr[CGROUP_AW-1:0]];
      cg_bkt_r   <= cg_bkt_mem[rd.addr[CGROUP_AW-1:0]];
      rd_lvl_r   <= rd.lvl;
    end
  end

  always_comb begin
    case (rd_lvl_r)
      LVL_CONN:   rd_data = {conn_lim_r, conn_bkt_r};
      LVL_PID:    rd_data = {pid_lim_r, pid_bkt_r};
      LVL_CGROUP: rd_data = {cg_lim_r, cg_bkt_r};
      default:    rd_data = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/htbp_bucket.sv =====
// ----------------------------------------------------------------------------
// htbp_bucket
// Shared bucket unit: refill by rate times elapsed time over one second,
// clamp to burst, then charge the packet.
// ----------------------------------------------------------------------------
`default_nettype none
module htbp_bucket (
  input  wire                     clk,
  input  wire                     rst_n,
  input  htbp_pkg::htbp_bkt_req_t req,
  output htbp_pkg::htbp_bkt_rsp_t rsp
);
  import htbp_pkg::*;

  htbp_bstate_t bst_r, bst_nxt;

  logic [TIME_W-1:0]  sh_r;      // multiplicand: shifted rate, then the scaled product
  logic [TIME_W-1:0]  el_r;      // multiplier, one chunk per step: elapsed, then reciprocal
  logic [TIME_W-1:0]  acc_r;     // rate times elapsed, modulo 2^64
  logic [TIME_W+MUL_CHUNK-1:0] div_r;  // reciprocal product, low chunk dropped per step
  logic [STEP_W-1:0]  cnt_r;
  logic [BURST_W-1:0] burst_r;
  logic [TOK_W-1:0]   tok_r;
  logic [TIME_W-1:0]  last_r;
  logic [TIME_W-1:0]  now_r;
  logic [BYTES_W-1:0] bytes_r;
  logic               pass_r;
  logic               lim_r;

  logic               unlimited;
  logic [TOK_W-1:0]   tok0;
  logic [TIME_W-1:0]  last0;
  logic [TIME_W-1:0]  elapsed;
  logic               refill;
  logic [TIME_W+MUL_CHUNK-1:0] prod;
  logic [TIME_W-1:0]  acc_sum;
  logic [TIME_W-1:0]  gain;
  logic [TIME_W:0]    sum;

  assign unlimited = (req.rate == '0) || (req.burst == '0);
  assign tok0      = (req.last == '0) ? req.burst : req.tokens;
  assign last0     = (req.last == '0) ? req.now : req.last;
  assign elapsed   = req.now - last0;
  assign refill    = (elapsed != '0) && !elapsed[TIME_W-1];
  assign prod      = sh_r * el_r[MUL_CHUNK-1:0];
  assign acc_sum   = acc_r + prod[TIME_W-1:0];
  assign gain      = TIME_W'(div_r >> DIV_POST_SHIFT);
  assign sum       = {1'b0, TIME_W'(tok_r)} + {1'b0, gain};

  always_comb begin
    bst_nxt = bst_r;
    case (bst_r)
      B_IDLE: begin
        if (req.start) begin
          if (unlimited) begin
            bst_nxt = B_DONE;
          end else if (refill) begin
            bst_nxt = B_MUL;
          end else begin
            bst_nxt = B_CHECK;
          end
        end
      end
      B_MUL:   if (cnt_r == STEP_W'(MUL_STEPS - 1)) bst_nxt = B_DIV;
      B_DIV:   if (cnt_r == STEP_W'(MUL_STEPS - 1)) bst_nxt = B_SUM;
      B_SUM:   bst_nxt = B_CHECK;
      B_CHECK: bst_nxt = B_DONE;
      B_DONE:  bst_nxt = B_IDLE;
      default: bst_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r <= B_IDLE;
    end else begin
      bst_r <= bst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (bst_r)
      B_IDLE: begin
        if (req.start) begin
          sh_r    <= TIME_W'(req.rate);
          el_r    <= elapsed;
          acc_r   <= '0;
          cnt_r   <= '0;
          burst_r <= req.burst;
          tok_r   <= tok0;
          last_r  <= last0;
          now_r   <= req.now;
          bytes_r <= req.bytes;
          lim_r   <= !unlimited;
          pass_r  <= 1'b1;
        end
      end
      B_MUL: begin
        acc_r <= acc_sum;
        if (cnt_r == STEP_W'(MUL_STEPS - 1)) begin
          // divide by one second: drop the power of two, then multiply by the reciprocal
          sh_r  <= acc_sum >> DIV_PRE_SHIFT;
          el_r  <= DIV_RECIP;
          div_r <= '0;
          cnt_r <= '0;
        end else begin
          sh_r  <= sh_r << MUL_CHUNK;
          el_r  <= el_r >> MUL_CHUNK;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      B_DIV: begin
        div_r <= (div_r >> MUL_CHUNK) + prod;
        el_r  <= el_r >> MUL_CHUNK;
        cnt_r <= cnt_r + 1'b1;
      end
      B_SUM: begin
        tok_r  <= (sum > (TIME_W+1)'(burst_r)) ? burst_r : sum[TOK_W-1:0];
        last_r <= now_r;
      end
      B_CHECK: begin
        if (tok_r >= TOK_W'(bytes_r)) begin
          tok_r  <= tok_r - TOK_W'(bytes_r);
          pass_r <= 1'b1;
        end else begin
          pass_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp.done    = (bst_r == B_DONE);
    rsp.pass    = pass_r;
    rsp.limited = lim_r;
    rsp.tokens  = tok_r;
    rsp.last    = last_r;
  end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hierarchical token bucket policer: a directed
// table and random packet and limit traffic over several global settings, each
// result checked against a fixed expectation or an in-bench model of the four bucket levels.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import htbp_pkg::*;

  localparam bit REG_GLOBAL_RATE  = 1'b0;
  localparam bit REG_GLOBAL_BURST = 1'b1;
  localparam int SLOTS            = 1024;
  localparam int DRAIN_CYCLES     = 400;
  localparam int HOLD_CYCLES      = 3000;
  localparam int RANDOM_ITEMS     = 1720;

  typedef struct {
    htbp_op_t          op;
    logic [9:0]        conn;
    logic [9:0]        pid;
    logic [9:0]        cgrp;
    logic [63:0]       now;
    logic [15:0]       bytes;
    logic [1:0]        tlvl;
    logic [9:0]        tidx;
    logic [39:0]       nrate;
    logic [31:0]       nburst;
  } pkt_t;

  typedef struct {
    logic        pass;
    htbp_level_t lvl;
  } verdict_t;

  typedef struct {
    pkt_t     pkt;
    bit       typed;
    verdict_t want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [199:0] in_tdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   out_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [39:0]  cfg_wdata = '0;

  hierarchical_token_bucket_policer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // bucket tables of the shadow policer
  logic [39:0] m_rate  [3][SLOTS];
  logic [31:0] m_burst [3][SLOTS];
  logic [31:0] m_tok   [3][SLOTS];
  logic [63:0] m_last  [3][SLOTS];
  logic [39:0] m_grate;
  logic [31:0] m_gburst;
  logic [31:0] m_gtok;
  logic [63:0] m_glast;

  verdict_t    verdict_q[$];
  int          errors = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  bit          holding = 1'b0;
  logic [63:0] clock_ns = 64'd1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("hierarchical_token_bucket_policer regression: fail");
    $finish;
  end

  function automatic bit charge(input logic [39:0] rate, input logic [31:0] burst,
                                inout logic [31:0] tok, inout logic [63:0] last,
                                input logic [63:0] now, input logic [15:0] bytes);
    logic [63:0] elapsed;
    logic [63:0] gain;
    logic [63:0] sum;
    if (rate == 0 || burst == 0) return 1'b1;
    if (last == 0) begin
      last = now;
      tok  = burst;
    end
    elapsed = now - last;
    if (elapsed != 0 && !elapsed[63]) begin
      gain = ({24'd0, rate} * elapsed) / 64'd1000000000;
      sum  = {32'd0, tok} + gain;
      if (sum > {32'd0, burst}) sum = {32'd0, burst};
      tok  = sum[31:0];
      last = now;
    end
    if (tok >= {16'd0, bytes}) begin
      tok = tok - {16'd0, bytes};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t police(input pkt_t p);
    verdict_t    v;
    logic [9:0]  idx [3];
    htbp_level_t lv;
    v.pass = 1'b1;
    v.lvl  = LVL_CONN;
    if (p.op == OP_WRITE) begin
      if (p.tlvl != LVL_GLOBAL) begin
        m_rate[p.tlvl][p.tidx]  = p.nrate;
        m_burst[p.tlvl][p.tidx] = p.nburst;
      end
      return v;
    end
    idx[0] = p.conn;
    idx[1] = p.pid;
    idx[2] = p.cgrp;
    for (int l = 0; l < 3; l++) begin
      lv = htbp_level_t'(l);
      if (idx[l] != 0 &&
          !charge(m_rate[l][idx[l]], m_burst[l][idx[l]], m_tok[l][idx[l]],
                  m_last[l][idx[l]], p.now, p.bytes)) begin
        v.pass = 1'b0;
        v.lvl  = lv;
        return v;
      end
    end
    if (!charge(m_grate, m_gburst, m_gtok, m_glast, p.now, p.bytes)) begin
      v.pass = 1'b0;
      v.lvl  = LVL_GLOBAL;
    end
    return v;
  endfunction

  function automatic logic [199:0] pack(input pkt_t p);
    return {5'd0, p.nburst, p.nrate, p.tidx, p.tlvl, p.bytes, p.now,
            p.cgrp, p.pid, p.conn, p.op};
  endfunction

  function automatic pkt_t mk(input htbp_op_t op, input int c, input int pi, input int g,
                              input logic [63:0] now, input int bytes, input int tl,
                              input int ti, input logic [39:0] r, input logic [31:0] b);
    pkt_t p;
    p.op = op; p.conn = 10'(c); p.pid = 10'(pi); p.cgrp = 10'(g); p.now = now;
    p.bytes = 16'(bytes); p.tlvl = 2'(tl); p.tidx = 10'(ti); p.nrate = r; p.nburst = b;
    return p;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [9:0] pick_slot();
    if ($urandom_range(0, 19) == 0) return 10'($urandom);
    return 10'($urandom_range(0, 7));
  endfunction

  function automatic pkt_t rand_pkt();
    pkt_t p;
    int   k;
    p.conn = pick_slot(); p.pid = pick_slot(); p.cgrp = pick_slot();
    p.tlvl = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    p.tidx = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(1, 7));
    k = $urandom_range(0, 9);
    p.nrate  = (k == 0) ? 40'd0 : (k == 1) ? {8'($urandom), 32'($urandom)} :
               40'($urandom_range(100000, 100000000));
    k = $urandom_range(0, 9);
    p.nburst = (k == 0) ? 32'd0 : (k == 1) ? 32'($urandom) :
               32'($urandom_range(500, 40000));
    p.bytes  = ($urandom_range(0, 19) == 0) ? 16'hFFFF :
               ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
    k = $urandom_range(0, 99);
    if (k < 3) p.now = clock_ns - $urandom_range(1, 50000);
    else if (k < 5) p.now = 64'd0;
    else if (k < 6) p.now = rnd64();
    else begin
      clock_ns = clock_ns + $urandom_range(0, 30000);
      p.now = clock_ns;
    end
    p.op = ($urandom_range(0, 99) < 12) ? OP_WRITE : OP_POLICE;
    return p;
  endfunction

  // offer one item, hold it until accepted, then predict its result
  task automatic send(input pkt_t p, input bit typed, input verdict_t want);
    verdict_t v;
    if (!no_idle && $urandom_range(0, 99) < 26) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tdata  = pack(p);
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    v = police(p);
    verdict_q.push_back(typed ? want : v);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_global(input logic [39:0] rate, input logic [31:0] burst);
    drain();
    cfg_we = 1'b1; cfg_index = REG_GLOBAL_RATE; cfg_wdata = rate;
    @(negedge clk);
    cfg_index = REG_GLOBAL_BURST; cfg_wdata = {8'd0, burst};
    @(negedge clk);
    cfg_we = 1'b0;
    m_grate  = rate;
    m_gburst = burst;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (holding) out_tready <= 1'b0;
    else if (no_idle) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 99) >= 26);
  end

  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holding  = 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%t unexpected result: expected none, actual %h", $realtime, out_tdata);
        errors++;
      end else begin
        w = verdict_q.pop_front();
        if (out_tdata[0] !== w.pass || out_tdata[2:1] !== w.lvl) begin
          $display("%t mismatch: expected pass %b level %0d, actual pass %b level %0d",
                   $realtime, w.pass, w.lvl, out_tdata[0], out_tdata[2:1]);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t     rows[$];
    verdict_t ok;
    verdict_t none;
    pkt_t     p;
    ok.pass = 1'b1;  ok.lvl = LVL_CONN;
    none.pass = 1'b0; none.lvl = LVL_CONN;
    for (int l = 0; l < 3; l++)
      for (int i = 0; i < SLOTS; i++) begin
        m_rate[l][i] = '0; m_burst[l][i] = '0; m_tok[l][i] = '0; m_last[l][i] = '0;
      end
    m_grate = '0; m_gburst = '0; m_gtok = '0; m_glast = '0;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // first packet with every level open passes
    rows.push_back('{mk(OP_POLICE, 0, 0, 0, 64'd100, 65535, 0, 0, 0, 0), 1, ok});
    set_global_rows: begin end
    foreach (rows[i]) send(rows[i].pkt, rows[i].typed, rows[i].want);
    rows.delete();

    set_global(40'd1000, 32'd2000);
    rows.push_back('{mk(OP_WRITE, 0, 0, 0, 0, 0, LVL_CONN, 1, 40'd1000, 32'd100), 1, ok});
    // unknown target level writes nothing
    rows.push_back('{mk(OP_WRITE, 5, 5, 5, 0, 0, 3, 1, 40'hFF_FFFF_FFFF, '1), 1, ok});
    rows.push_back('{mk(OP_POLICE, 1, 0, 0, 64'd1000, 100, 0, 0, 0, 0), 1, ok});
    none.lvl = LVL_CONN;
    rows.push_back('{mk(OP_POLICE, 1, 0, 0, 64'd1000, 1, 0, 0, 0, 0), 1, none});
    // time going backwards: no refill
    rows.push_back('{mk(OP_POLICE, 1, 0, 0, 64'd500, 1, 0, 0, 0, 0), 1, none});
    // over the global burst
    none.lvl = LVL_GLOBAL;
    rows.push_back('{mk(OP_POLICE, 0, 0, 0, 64'd2000, 2001, 0, 0, 0, 0), 1, none});
    rows.push_back('{mk(OP_WRITE, 0, 0, 0, 0, 0, LVL_PID, 2, 40'hFF_FFFF_FFFF, '1), 1, ok});
    // zero time stamp reloads twice
    rows.push_back('{mk(OP_POLICE, 0, 2, 0, 64'd0, 65535, 0, 0, 0, 0), 0, ok});
    rows.push_back('{mk(OP_POLICE, 0, 2, 0, 64'd0, 65535, 0, 0, 0, 0), 0, ok});
    rows.push_back('{mk(OP_WRITE, 0, 0, 0, 0, 0, LVL_CGROUP, 3, 40'd1, 32'd10), 1, ok});
    none.lvl = LVL_CGROUP;
    rows.push_back('{mk(OP_POLICE, 0, 0, 3, 64'd5, 11, 0, 0, 0, 0), 1, none});
    rows.push_back('{mk(OP_WRITE, 0, 0, 0, 0, 0, LVL_CGROUP, 1023, 40'd5, 32'd5), 1, ok});
    rows.push_back('{mk(OP_POLICE, 1023, 1023, 1023, '1, 65535, 3, 1023, '1, '1), 0, ok});
    rows.push_back('{mk(OP_POLICE, 1, 2, 3, 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0),
                     0, ok});
    rows.push_back('{mk(OP_POLICE, 1, 2, 3, 64'd3_000_000_000, 50, 0, 0, 0, 0), 0, ok});
    foreach (rows[i]) send(rows[i].pkt, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_global(40'd0, 32'd0);
        1: set_global(40'd50000000, 32'd30000);
        2: set_global(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
        3: set_global(40'd2000000, 32'd0);
        default: set_global(40'd1000000, 32'd5000);
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
        no_idle = (ph == 1 && n >= 100 && n < 250);
        if (ph == 4 && n == 50) hold_req = 1'b1;
        p = rand_pkt();
        send(p, 1'b0, ok);
      end
    end
    no_idle = 1'b0;
    drain();
    if (errors == 0) begin
      $display("hierarchical_token_bucket_policer regression: pass");
    end else begin
      $display("hierarchical_token_bucket_policer regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
